### design/link_layer_ip_header_locator_defines.svh
// ----------------------------------------------------------------------------
// link_layer_ip_header_locator_defines
// assertion macros used by the locator top module
// ----------------------------------------------------------------------------
`ifndef LINK_LAYER_IP_HEADER_LOCATOR_DEFINES_SVH
`define LINK_LAYER_IP_HEADER_LOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LLHL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define LLHL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/llhl_pkg.sv
// ----------------------------------------------------------------------------
// llhl_pkg
// types, codes and constants of the link-layer ip header locator
// ----------------------------------------------------------------------------
package llhl_pkg;

	// link type register codes
	localparam logic [3:0] LINK_RAW      = 4'd0;
	localparam logic [3:0] LINK_HOST_RAW = 4'd1;
	localparam logic [3:0] LINK_ETHER    = 4'd2;
	localparam logic [3:0] LINK_FDDI     = 4'd3;
	localparam logic [3:0] LINK_ATM      = 4'd4;
	localparam logic [3:0] LINK_SUNATM   = 4'd5;
	localparam logic [3:0] LINK_COOKED   = 4'd6;
	localparam logic [3:0] LINK_HDLC     = 4'd7;
	localparam logic [3:0] LINK_WIFI     = 4'd8;
	localparam logic [3:0] LINK_PRISM    = 4'd9;
	localparam logic [3:0] LINK_RESET    = LINK_HOST_RAW;

	// protocol constants
	localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6   = 16'h86dd;
	localparam logic [15:0] ETYPE_VLAN   = 16'h8100;
	localparam logic [15:0] LLC_SNAP     = 16'haaaa;
	localparam logic [15:0] LLC_NLPID    = 16'h0606;
	localparam logic [23:0] OUI_ENCAP    = 24'h000000;
	localparam logic [23:0] OUI_BRIDGE   = 24'h0000f8;
	localparam logic [23:0] OUI_8021     = 24'h0080c2;
	localparam logic [15:0] PID_ETH_FCS  = 16'h0001;
	localparam logic [15:0] PID_ETH      = 16'h0007;
	localparam logic [15:0] PID_FDDI_FCS = 16'h0004;
	localparam logic [15:0] PID_FDDI     = 16'h000a;
	localparam logic [3:0]  IP_V4        = 4'd4;
	localparam logic [3:0]  IP_V6        = 4'd6;
	localparam logic [5:0]  IPV6_HDR     = 6'd40;

	// parse layer of one decapsulation chain
	typedef enum logic [2:0] {
		K_ETHER,
		K_ETHER_NV,
		K_VLAN,
		K_FDDI,
		K_ATM,
		K_WIFI,
		K_IP,
		K_FAIL
	} kind_t;

	// verdict of one chain at the frame end
	typedef struct packed {
		logic        found;
		logic [8:0]  offset;
		logic [3:0]  version;
		logic [5:0]  hbytes;
		logic [31:0] dst;
	} chain_res_t;

	// one chain per distinct starting point
	localparam int NCHAIN     = 9;
	localparam int CH_RAW     = 0;
	localparam int CH_ETHER   = 1;
	localparam int CH_FDDI    = 2;
	localparam int CH_ATM     = 3;
	localparam int CH_SUNATM  = 4;
	localparam int CH_COOKED  = 5;
	localparam int CH_HDLC    = 6;
	localparam int CH_WIFI    = 7;
	localparam int CH_PRISM   = 8;

	function automatic kind_t chain_kind(input int i);
		kind_t k;
		case (i)
			CH_RAW:    k = K_IP;
			CH_ETHER:  k = K_ETHER;
			CH_FDDI:   k = K_FDDI;
			CH_ATM:    k = K_ATM;
			CH_SUNATM: k = K_ATM;
			CH_COOKED: k = K_ETHER_NV;
			CH_HDLC:   k = K_ETHER_NV;
			CH_WIFI:   k = K_WIFI;
			CH_PRISM:  k = K_WIFI;
			default:   k = K_FAIL;
		endcase
		return k;
	endfunction

	// layer position: type field for ethernet-like layers, else layer start
	function automatic int chain_start(input int i);
		int s;
		case (i)
			CH_ETHER:  s = 12;
			CH_SUNATM: s = 4;
			CH_COOKED: s = 14;
			CH_HDLC:   s = 2;
			CH_PRISM:  s = 144;
			default:   s = 0;
		endcase
		return s;
	endfunction

	function automatic logic is_ip(input logic [15:0] t);
		return (t == ETYPE_IPV4) || (t == ETYPE_IPV6);
	endfunction

endpackage

### design/link_layer_ip_header_locator.sv
// result: registered, valid in the cycle after the last byte of a frame is accepted
// throughput: one frame byte per cycle unless an untaken result holds in_ready low, frames back to back with no gap
// every link type is walked in parallel, the register picks the chain at the last byte
// reset: link type host raw, byte count zero, all chains at their start, no result
// ----------------------------------------------------------------------------
// link_layer_ip_header_locator
// finds the ipv4 or ipv6 header behind a configurable link layer, one result
// per frame
// ----------------------------------------------------------------------------
`include "link_layer_ip_header_locator_defines.svh"

module link_layer_ip_header_locator import llhl_pkg::*; #(
	parameter int MAX_FRAME_BYTES   = 65535,
	parameter int MAX_HEADER_OFFSET = 511
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        end_of_frame,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ip_found,
	output logic [8:0]  ip_offset,
	output logic [3:0]  ip_version,
	output logic [5:0]  ip_header_bytes,
	output logic [31:0] ipv4_destination
);

	localparam int LW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int PW = $clog2(MAX_HEADER_OFFSET + 65);

	logic [3:0]    link_type_q;
	logic [LW-1:0] pos_q, len;
	logic [63:0]   win_q, win_d;
	logic          acc, counted, eof;
	chain_res_t    res [NCHAIN];
	chain_res_t    sel, out_q;
	logic          out_valid_q;

	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;
	assign eof      = acc && end_of_frame;
	assign counted  = 32'(pos_q) < MAX_FRAME_BYTES;
	assign len      = counted ? pos_q + LW'(1) : pos_q;
	assign win_d    = {win_q[55:0], frame_byte};

	// link type register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) link_type_q <= LINK_RESET;
		else if (cfg_we) link_type_q <= cfg_wdata;
	end

	// byte count and byte window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			win_q <= '0;
		end else if (acc) begin
			win_q <= win_d;
			pos_q <= end_of_frame ? '0 : len;
		end
	end

	// one decapsulation chain per starting point
	for (genvar g = 0; g < NCHAIN; g++) begin : g_chain
		llhl_chain #(
			.MAX_HDR    (MAX_HEADER_OFFSET),
			.PW         (PW),
			.LW         (LW),
			.START_KIND (chain_kind(g)),
			.START_POS  (chain_start(g))
		) u_chain (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (acc && counted),
			.eof    (eof),
			.pos    (pos_q),
			.len    (len),
			.win    (win_d),
			.res    (res[g])
		);
	end

	// chain select by link type
	always_comb begin
		case (link_type_q)
			LINK_RAW, LINK_HOST_RAW: sel = res[CH_RAW];
			LINK_ETHER:              sel = res[CH_ETHER];
			LINK_FDDI:               sel = res[CH_FDDI];
			LINK_ATM:                sel = res[CH_ATM];
			LINK_SUNATM:             sel = res[CH_SUNATM];
			LINK_COOKED:             sel = res[CH_COOKED];
			LINK_HDLC:               sel = res[CH_HDLC];
			LINK_WIFI:               sel = res[CH_WIFI];
			LINK_PRISM:              sel = res[CH_PRISM];
			default:                 sel = '0;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (eof) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (eof) out_q <= sel;
	end

	assign out_valid        = out_valid_q;
	assign ip_found         = out_q.found;
	assign ip_offset        = out_q.offset;
	assign ip_version       = out_q.version;
	assign ip_header_bytes  = out_q.hbytes;
	assign ipv4_destination = out_q.dst;

	`LLHL_ASSERT_NXT(a_eof_gives_result, eof, out_valid, "frame end without a result")
	`LLHL_ASSERT_IMP(a_found_version, out_valid && ip_found,
		ip_version == IP_V4 || ip_version == IP_V6, "found header with bad version")
	`LLHL_ASSERT_IMP(a_none_zero, out_valid && !ip_found,
		ip_offset == '0 && ip_version == '0 && ip_header_bytes == '0
		&& ipv4_destination == '0, "no header but nonzero fields")
	`LLHL_ASSERT_IMP(a_v6_fields, out_valid && ip_found && ip_version == IP_V6,
		ip_header_bytes == IPV6_HDR && ipv4_destination == '0, "ipv6 result fields wrong")

endmodule

### design/llhl_chain.sv
// ----------------------------------------------------------------------------
// llhl_chain
// streaming walk of one nested encapsulation from a fixed start, capturing the
// ip header as it streams past, with the length check done on the last byte
// ----------------------------------------------------------------------------
module llhl_chain import llhl_pkg::*; #(
	parameter int    MAX_HDR    = 511,
	parameter int    PW         = 10,
	parameter int    LW         = 16,
	parameter kind_t START_KIND = K_IP,
	parameter int    START_POS  = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             eof,
	input  logic [LW-1:0]    pos,
	input  logic [LW-1:0]    len,
	input  logic [63:0]      win,
	output chain_res_t       res
);

	localparam int HEAD = MAX_HDR + 64;

	kind_t          kind_q, kind_d;
	logic [PW-1:0]  at_q, at_d, min_q, min_d, p;
	logic [7:0]     first_q, first_d;
	logic           fok_q, fok_d, in_head;
	logic [31:0]    dst_q, dst_d;
	logic [15:0]    t16;
	logic [7:0]     b0, b1;
	logic [23:0]    oui;
	logic [3:0]     hl;
	logic [5:0]     hb;

	assign in_head = 32'(pos) < HEAD;
	assign p       = PW'(pos);
	assign t16     = win[15:0];
	assign b0      = win[15:8];
	assign b1      = win[7:0];
	assign oui     = win[39:16];

	// layer walk on the current byte
	always_comb begin
		kind_d  = kind_q;
		at_d    = at_q;
		min_d   = min_q;
		first_d = first_q;
		fok_d   = fok_q;
		dst_d   = dst_q;
		if (step && in_head) begin
			case (kind_q)
				K_FDDI: begin
					if (p == at_q) begin
						if (b1[7:3] == 5'b01010) begin
							kind_d = K_ATM;
							at_d   = at_q + PW'(13);
							min_d  = (min_q > at_q + PW'(21)) ? min_q : at_q + PW'(21);
						end else begin
							kind_d = K_FAIL;
						end
					end
				end
				K_ATM: begin
					if (p == at_q + PW'(1)) begin
						if (t16 == LLC_NLPID) begin
							kind_d = K_IP;
							at_d   = at_q + PW'(4);
							min_d  = (min_q > at_q + PW'(4)) ? min_q : at_q + PW'(4);
						end else if (t16 != LLC_SNAP) begin
							kind_d = K_FAIL;
						end
					end else if (p == at_q + PW'(7)) begin
						if (oui == OUI_ENCAP || oui == OUI_BRIDGE) begin
							// embedded ethernet whose type field is the pid
							if (is_ip(t16)) begin
								kind_d = K_IP;
								at_d   = at_q + PW'(8);
							end else if (t16 == ETYPE_VLAN) begin
								kind_d = K_VLAN;
								at_d   = at_q + PW'(6);
							end else begin
								kind_d = K_FAIL;
							end
						end else if (oui == OUI_8021 && (t16 == PID_ETH_FCS || t16 == PID_ETH)) begin
							kind_d = K_ETHER;
							at_d   = at_q + PW'(20);
						end else if (oui == OUI_8021
							&& (t16 == PID_FDDI_FCS || t16 == PID_FDDI)) begin
							kind_d = K_FDDI;
							at_d   = at_q + PW'(9);
						end else begin
							kind_d = K_FAIL;
						end
					end
				end
				K_WIFI: begin
					if (p == at_q + PW'(1)) begin
						if ((b0 & 8'h0c) == 8'h08) begin
							kind_d = K_ATM;
							at_d   = at_q + ((b1[1:0] == 2'b11) ? PW'(30) : PW'(24));
							min_d  = (min_q > at_q + PW'(24)) ? min_q : at_q + PW'(24);
						end else begin
							kind_d = K_FAIL;
						end
					end
				end
				K_ETHER, K_ETHER_NV: begin
					if (p == at_q + PW'(1)) begin
						if (is_ip(t16)) begin
							kind_d = K_IP;
							at_d   = at_q + PW'(2);
						end else if (t16 == ETYPE_VLAN && kind_q == K_ETHER) begin
							kind_d = K_VLAN;
						end else begin
							kind_d = K_FAIL;
						end
					end
				end
				K_VLAN: begin
					if (p == at_q + PW'(5)) begin
						if (is_ip(t16)) begin
							kind_d = K_IP;
							at_d   = at_q + PW'(6);
						end else begin
							kind_d = K_FAIL;
						end
					end
				end
				K_IP: begin
					if (p == at_q) begin
						first_d = b1;
						fok_d   = 1'b1;
					end
					if (p >= at_q + PW'(16) && p <= at_q + PW'(19))
						dst_d = {dst_q[23:0], b1};
				end
				default: ;
			endcase
			// too deep a layer or header
			case (kind_d)
				K_FDDI, K_ATM, K_WIFI, K_IP:
					if (32'(at_d) > MAX_HDR) kind_d = K_FAIL;
				K_ETHER, K_ETHER_NV, K_VLAN:
					if (32'(at_d) > MAX_HDR + 12) kind_d = K_FAIL;
				default: ;
			endcase
		end
	end

	// header check against the frame length
	assign hl = first_d[3:0];
	assign hb = {hl, 2'b00};

	always_comb begin
		res = '0;
		if (kind_d == K_IP && fok_d && 32'(len) >= 32'(min_d)) begin
			if (first_d[7:4] == IP_V4 && hl >= 4'd5 && 32'(at_d) + 32'(hb) <= 32'(len)) begin
				res.found   = 1'b1;
				res.offset  = at_d[8:0];
				res.version = IP_V4;
				res.hbytes  = hb;
				res.dst     = dst_d;
			end else if (first_d[7:4] == IP_V6 && 32'(at_d) + 32'd40 <= 32'(len)) begin
				res.found   = 1'b1;
				res.offset  = at_d[8:0];
				res.version = IP_V6;
				res.hbytes  = IPV6_HDR;
			end
		end
	end

	// chain state, restarted after each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= START_KIND;
			at_q    <= PW'(START_POS);
			min_q   <= '0;
			fok_q   <= 1'b0;
			first_q <= '0;
			dst_q   <= '0;
		end else if (eof) begin
			kind_q  <= START_KIND;
			at_q    <= PW'(START_POS);
			min_q   <= '0;
			fok_q   <= 1'b0;
			first_q <= '0;
			dst_q   <= '0;
		end else begin
			kind_q  <= kind_d;
			at_q    <= at_d;
			min_q   <= min_d;
			fok_q   <= fok_d;
			first_q <= first_d;
			dst_q   <= dst_d;
		end
	end

endmodule
